### rtl/ntx_pkg.sv
package ntx_pkg;

   // Character codes the scanner recognizes.
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UPPER_E = 8'h45;
   localparam logic [7:0] CH_LOWER_E = 8'h65;
   localparam logic [7:0] CH_LOWER_I = 8'h69;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_PERIOD = 8'h2E;
   localparam logic [7:0] CH_COMMA  = 8'h2C;

   localparam int CNT_W = 7;
   localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECIMAL_IS_PERIOD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEPARATORS_ENABLED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REAL_ONLY          = 2'd2;

   // Result queue geometry.
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_PUSH    = 3;

   typedef enum logic [3:0] {
      PH_NONE    = 4'd0,
      PH_SIGN    = 4'd1,
      PH_INT     = 4'd2,
      PH_FRAC    = 4'd3,
      PH_E       = 4'd4,
      PH_EXP     = 4'd5,
      PH_POSTIM  = 4'd6,
      PH_NEXT    = 4'd7,
      PH_ILLEGAL = 4'd15
   } phase_type;

   typedef struct packed {
      logic decimal_is_period;
      logic separators_enabled;
      logic real_only;
   } cfg_type;

   typedef struct packed {
      logic             kind;
      logic [7:0]       out_char;
      logic             stop_kind;
      logic [CNT_W-1:0] consumed;
      logic [CNT_W-1:0] out_length;
      logic [CNT_W-1:0] digit_total;
      logic             imaginary;
      logic             last;
   } result_type;

   typedef struct packed {
      logic [1:0]       count;
      result_type [2:0] slot;
   } push_type;

   typedef struct packed {
      logic              ready;
      logic [QLVL_W-1:0] level;
   } queue_status_type;

endpackage

### rtl/numeric_token_extractor_core.sv
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_ready   req_ch, req_end_of_text
// rsp_      out        rsp_valid / rsp_ready   rsp_kind ... rsp_last
// csr_      in         csr_wr_en (no wait)     csr_index, csr_wdata
//
// An item is examined in the cycle it is accepted; its zero to three result items
// land in an eight-entry result queue at that edge, and the first can leave in the cycle after.
// A new item is accepted every cycle while the queue has room for three more results,
// so the input runs at one item per cycle as long as results are taken as fast as made.
// Once the output stalls, the queue alone sets how far the input may run ahead.
// Reset is synchronous: it empties the queue, restarts the scan and restores defaults.
module numeric_token_extractor_core
   import ntx_pkg::*;
#(
   parameter int MAX_CHARS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_ch,
   input  logic                 req_end_of_text,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_kind,
   output logic [7:0]           rsp_out_char,
   output logic                 rsp_stop_kind,
   output logic [CNT_W-1:0]     rsp_consumed,
   output logic [CNT_W-1:0]     rsp_out_length,
   output logic [CNT_W-1:0]     rsp_digit_total,
   output logic                 rsp_imaginary,
   output logic                 rsp_last,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   push_type         push;
   result_type       head;
   queue_status_type qstat;
   logic             accept;

   // The configuration registers take a write at the clock edge while csr_wr_en is high; an
   // index beyond the list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DECIMAL_IS_PERIOD:  cfg_in.decimal_is_period = csr_wdata;
            CSR_SEPARATORS_ENABLED: cfg_in.separators_enabled = csr_wdata;
            CSR_REAL_ONLY:          cfg_in.real_only = csr_wdata;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decimal_is_period <= 1'b1;
         cfg_ff.separators_enabled <= 1'b0;
         cfg_ff.real_only <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input is taken only while the queue can hold a full burst of results.
   assign req_ready = qstat.ready;
   assign accept = req_valid && req_ready;

   // The scanner holds the parse state and turns each character into its results.
   ntx_scan #(
      .MAX_CHARS(MAX_CHARS)
   ) u_scan (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .ch(req_ch),
      .end_of_text(req_end_of_text),
      .cfg(cfg_ff),
      .push(push)
   );

   // The queue parts the two sides and hands out one result item per cycle while rsp_ready is high.
   ntx_rsp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .pop_ready(rsp_ready),
      .head_valid(rsp_valid),
      .head(head),
      .status(qstat)
   );

   assign rsp_kind = head.kind;
   assign rsp_out_char = head.out_char;
   assign rsp_stop_kind = head.stop_kind;
   assign rsp_consumed = head.consumed;
   assign rsp_out_length = head.out_length;
   assign rsp_digit_total = head.digit_total;
   assign rsp_imaginary = head.imaginary;
   assign rsp_last = head.last;

   // A status item always closes the burst of its character.
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_last)
      else $error("status item without last");

   // The queue never holds more than its depth.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      qstat.level <= QLVL_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // In a full burst only the third item carries last.
   a_burst_last: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd3 |-> push.slot[2].last && !push.slot[1].last && !push.slot[0].last)
      else $error("last misplaced in a burst of three");

   // Nothing is pushed unless an input item was accepted.
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> accept)
      else $error("results pushed without an accepted item");

endmodule

### rtl/ntx_scan.sv
module ntx_scan
   import ntx_pkg::*;
#(
   parameter int MAX_CHARS = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  logic [7:0] ch,
   input  logic     end_of_text,
   input  cfg_type  cfg,
   output push_type push
);

   localparam int IDX_W = $clog2(MAX_CHARS + 1);
   localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_CHARS);
   localparam logic [CNT_W-1:0] MAX_CONS  = CNT_W'(MAX_CHARS % 128);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] digit_ff, digit_in;
   logic             imag_ff, imag_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [CNT_W-1:0] emit_ff, emit_in;
   logic             finished_ff, finished_in;

   function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [CNT_W-1:0] idx_to_cnt(logic [IDX_W-1:0] v);
      logic [IDX_W+CNT_W-1:0] wide;
      wide = {{CNT_W{1'b0}}, v};
      return wide[CNT_W-1:0];
   endfunction

   function automatic result_type char_item(logic [7:0] c);
      result_type r;
      r = '0;
      r.out_char = c;
      return r;
   endfunction

   logic [7:0]       dot_ch, sep_ch, c_a, c_b;
   logic             e_a, e_b, lone, stat, stop_k, stopped;
   logic [CNT_W-1:0] cons;
   phase_type        ph;
   result_type       tmp [0:3];
   logic [1:0]       n;
   result_type       st;

   always_comb begin
      dot_ch = cfg.decimal_is_period ? CH_PERIOD : CH_COMMA;
      sep_ch = cfg.decimal_is_period ? CH_COMMA : CH_PERIOD;
      ph = phase_ff;
      digit_in = digit_ff;
      imag_in = imag_ff;
      index_in = index_ff;
      emit_in = emit_ff;
      finished_in = finished_ff;
      e_a = 1'b0;
      e_b = 1'b0;
      c_a = CH_ZERO;
      c_b = CH_ZERO;
      lone = 1'b0;
      stat = 1'b0;
      stop_k = 1'b1;
      stopped = 1'b0;
      cons = '0;

      if (finished_ff) begin
         // Waiting for the end of the text; nothing is reported.
      end else if (index_ff >= IDX_LIMIT) begin
         stat = 1'b1;
         cons = MAX_CONS;
         finished_in = 1'b1;
      end else begin
         if (ch == CH_PLUS || ch == CH_MINUS) begin
            if (ph inside {PH_NONE, PH_E}) begin
               e_a = (ch == CH_MINUS);
               c_a = ch;
               ph = (ph == PH_NONE) ? PH_SIGN : PH_EXP;
            end else if (ph inside {PH_INT, PH_FRAC, PH_EXP, PH_POSTIM}) begin
               ph = PH_NEXT;
            end else begin
               ph = PH_ILLEGAL;
            end
         end else if (ch inside {[CH_ZERO:CH_NINE]}) begin
            if (ph inside {PH_NONE, PH_SIGN, PH_INT, PH_FRAC, PH_EXP, PH_E}) begin
               e_a = 1'b1;
               c_a = ch;
               digit_in = sat_inc(digit_in);
               if (ph inside {PH_NONE, PH_SIGN}) begin
                  ph = PH_INT;
               end else if (ph == PH_E) begin
                  ph = PH_EXP;
               end
            end else begin
               ph = PH_ILLEGAL;
            end
         end else if (cfg.separators_enabled && ch == sep_ch) begin
            if (!(ph inside {PH_INT, PH_FRAC})) begin
               ph = PH_ILLEGAL;
            end
         end else if (ch == dot_ch) begin
            if (ph inside {PH_NONE, PH_SIGN, PH_INT}) begin
               e_a = 1'b1;
               if (ph != PH_INT) begin
                  c_a = CH_ZERO;
                  e_b = 1'b1;
                  c_b = dot_ch;
               end else begin
                  c_a = dot_ch;
               end
               ph = PH_FRAC;
            end else begin
               ph = PH_ILLEGAL;
            end
         end else if (ch == CH_UPPER_E || ch == CH_LOWER_E) begin
            if (ph inside {PH_SIGN, PH_INT, PH_FRAC}) begin
               e_a = 1'b1;
               if (ph == PH_SIGN) begin
                  c_a = CH_ONE;
                  digit_in = sat_inc(digit_in);
                  e_b = 1'b1;
                  c_b = CH_LOWER_E;
               end else begin
                  c_a = CH_LOWER_E;
               end
               ph = PH_E;
            end else begin
               ph = PH_ILLEGAL;
            end
         end else if (ch == CH_LOWER_I && !cfg.real_only) begin
            if (ph inside {PH_NONE, PH_SIGN}) begin
               imag_in = 1'b1;
               ph = PH_INT;
            end else if (ph inside {PH_INT, PH_FRAC, PH_EXP}) begin
               imag_in = 1'b1;
               ph = PH_POSTIM;
            end else begin
               ph = PH_ILLEGAL;
            end
         end else if (ch == CH_SPACE) begin
            if (ph inside {PH_INT, PH_FRAC, PH_EXP, PH_POSTIM}) begin
               ph = PH_NEXT;
            end else if (!(ph inside {PH_NONE, PH_SIGN})) begin
               ph = PH_ILLEGAL;
            end
         end else if (ph != PH_NONE) begin
            ph = PH_ILLEGAL;
         end

         // A header with no digits is skipped, unless an i gives it a lone digit.
         if (ph inside {PH_ILLEGAL, PH_NEXT}) begin
            if (digit_in == '0 && imag_in) begin
               lone = 1'b1;
               digit_in = sat_inc(digit_in);
               stopped = 1'b1;
            end else if (digit_in == '0) begin
               ph = PH_NONE;
            end else begin
               stopped = 1'b1;
            end
         end

         if (e_a) emit_in = sat_inc(emit_in);
         if (e_b) emit_in = sat_inc(emit_in);
         if (lone) emit_in = sat_inc(emit_in);

         if (stopped) begin
            stat = 1'b1;
            stop_k = (ph != PH_NEXT);
            cons = idx_to_cnt(index_ff);
            finished_in = 1'b1;
         end else begin
            index_in = index_ff + 1'b1;
            if (end_of_text) begin
               stat = 1'b1;
               cons = idx_to_cnt(index_in);
               finished_in = 1'b1;
            end
         end
      end
      phase_in = ph;

      st = '0;
      st.kind = 1'b1;
      st.stop_kind = stop_k;
      st.consumed = cons;
      st.out_length = emit_in;
      st.digit_total = digit_in;
      st.imaginary = imag_in;

      // Pack the items of this character in order.
      for (int k = 0; k < 4; k++) begin
         tmp[k] = '0;
      end
      n = 2'd0;
      if (e_a) begin
         tmp[n] = char_item(c_a);
         n = n + 2'd1;
      end
      if (e_b) begin
         tmp[n] = char_item(c_b);
         n = n + 2'd1;
      end
      if (lone) begin
         tmp[n] = char_item(CH_ONE);
         n = n + 2'd1;
      end
      if (stat) begin
         tmp[n] = st;
         n = n + 2'd1;
      end
      if (n != 2'd0) begin
         tmp[n - 2'd1].last = 1'b1;
      end

      push.count = accept ? n : 2'd0;
      push.slot[0] = tmp[0];
      push.slot[1] = tmp[1];
      push.slot[2] = tmp[2];

      if (end_of_text) begin
         phase_in = PH_NONE;
         digit_in = '0;
         imag_in = 1'b0;
         index_in = '0;
         emit_in = '0;
         finished_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NONE;
         digit_ff <= '0;
         imag_ff <= 1'b0;
         index_ff <= '0;
         emit_ff <= '0;
         finished_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         digit_ff <= digit_in;
         imag_ff <= imag_in;
         index_ff <= index_in;
         emit_ff <= emit_in;
         finished_ff <= finished_in;
      end
   end

endmodule

### rtl/ntx_rsp_queue.sv
module ntx_rsp_queue
   import ntx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop_ready,
   output logic             head_valid,
   output result_type       head,
   output queue_status_type status
);

   result_type        mem [0:QUEUE_DEPTH-1];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0] level_ff, level_in;
   logic              pop;

   assign head_valid = (level_ff != '0);
   assign head = mem[rd_ptr_ff];
   assign pop = head_valid && pop_ready;

   // Room for the largest burst one character can cause.
   assign status.ready = (level_ff <= QLVL_W'(QUEUE_DEPTH - MAX_PUSH));
   assign status.level = level_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in = level_ff + QLVL_W'(push.count) - QLVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_PUSH; k++) begin
         if (k < int'(push.count)) begin
            mem[QPTR_W'(wr_ptr_ff + QPTR_W'(k))] <= push.slot[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff <= level_in;
      end
   end

endmodule

### tb/tb_numeric_token_extractor_core.sv
`timescale 1ns / 1ps

// Self-checking bench for the numeric token extractor. Characters go in one item per
// handshake; every result item is checked against a hand-written row or a behavioral
// scanner in this module that tracks the parse phase, counters and register settings.
module tb_numeric_token_extractor_core;
   import ntx_pkg::*;

   localparam int MAX_CHARS     = 64;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 150;
   localparam int DIRECTED_LEN  = 23;

   // One row of the directed table. When typed is set, want is the single result item
   // the row must produce, written out by hand; otherwise the scanner decides.
   typedef struct packed {
      logic [7:0] ch;
      logic       eot;
      logic       typed;
      result_type want;
   } stim_row_type;

   // Text 1 runs a sign, a bare decimal point, junk that drops the header, a number with
   // an exponent and an i, then a space that stops it. Text 2 is a lone i cut off by an
   // illegal byte. Text 3 is a sign followed by a bare exponent letter. Text 4 is a single
   // digit, and text 5 is junk only, so the text runs out with nothing found.
   localparam stim_row_type DIRECTED [DIRECTED_LEN] = '{
      '{8'hFF,      1'b0, 1'b0, '0},
      '{CH_MINUS,   1'b0, 1'b1, '{1'b0, CH_MINUS, 1'b0, 7'd0, 7'd0, 7'd0, 1'b0, 1'b1}},
      '{CH_PERIOD,  1'b0, 1'b0, '0},
      '{8'h00,      1'b0, 1'b0, '0},
      '{CH_NINE,    1'b0, 1'b0, '0},
      '{CH_ZERO,    1'b0, 1'b0, '0},
      '{CH_UPPER_E, 1'b0, 1'b0, '0},
      '{CH_MINUS,   1'b0, 1'b0, '0},
      '{CH_ZERO,    1'b0, 1'b0, '0},
      '{CH_LOWER_I, 1'b0, 1'b0, '0},
      '{CH_SPACE,   1'b0, 1'b1, '{1'b1, 8'h00, 1'b0, 7'd10, 7'd8, 7'd3, 1'b1, 1'b1}},
      '{CH_NINE,    1'b0, 1'b0, '0},
      '{8'h00,      1'b1, 1'b0, '0},
      '{CH_LOWER_I, 1'b0, 1'b0, '0},
      '{8'hFF,      1'b0, 1'b0, '0},
      '{CH_NINE,    1'b1, 1'b0, '0},
      '{CH_PLUS,    1'b0, 1'b0, '0},
      '{CH_LOWER_E, 1'b0, 1'b0, '0},
      '{CH_NINE,    1'b0, 1'b0, '0},
      '{CH_PLUS,    1'b1, 1'b0, '0},
      '{CH_ZERO,    1'b1, 1'b0, '0},
      '{CH_SPACE,   1'b0, 1'b0, '0},
      '{8'hFF,      1'b1, 1'b1, '{1'b1, 8'h00, 1'b1, 7'd2, 7'd0, 7'd0, 1'b0, 1'b1}}
   };

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [7:0]       req_ch;
   logic             req_end_of_text;
   logic             rsp_valid;
   logic             rsp_ready;
   logic             rsp_kind;
   logic [7:0]       rsp_out_char;
   logic             rsp_stop_kind;
   logic [CNT_W-1:0] rsp_consumed;
   logic [CNT_W-1:0] rsp_out_length;
   logic [CNT_W-1:0] rsp_digit_total;
   logic             rsp_imaginary;
   logic             rsp_last;
   logic             csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic             csr_wdata;

   numeric_token_extractor_core #(
      .MAX_CHARS(MAX_CHARS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_ch(req_ch),
      .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_out_char(rsp_out_char),
      .rsp_stop_kind(rsp_stop_kind),
      .rsp_consumed(rsp_consumed),
      .rsp_out_length(rsp_out_length),
      .rsp_digit_total(rsp_digit_total),
      .rsp_imaginary(rsp_imaginary),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Scanner state as the block should hold it, plus the register settings in force.
   cfg_type          cfg;
   phase_type        scan_phase;
   logic [CNT_W-1:0] digits_seen;
   logic             imag_seen;
   logic [CNT_W-1:0] char_pos;
   logic [CNT_W-1:0] chars_emitted;
   logic             scan_done;

   // Result items produced by the character being scanned, at most three.
   result_type       step_results [0:2];
   int               step_count;

   // Result items the block still owes, oldest first.
   result_type       token_results_due [$];

   // The character currently offered may carry a hand-written expectation.
   logic             typed_active;
   result_type       typed_want;

   logic [7:0]       text_buf [$];

   int send_idle_pct;
   int recv_idle_pct;
   int fail_count;
   int items_sent;
   int texts_sent;
   int results_checked;
   int status_seen;
   int settings_used;
   int cycle_count;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver withholds ready at random; with a zero percentage it never stalls.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // A hung handshake or a missing result ends the run here.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("FAIL numeric_token_extractor_core");
         $finish;
      end
   end

   task automatic clear_scan();
      scan_phase    = PH_NONE;
      digits_seen   = '0;
      imag_seen     = 1'b0;
      char_pos      = '0;
      chars_emitted = '0;
      scan_done     = 1'b0;
   endtask

   task automatic count_digit();
      if (digits_seen < CNT_MAX) digits_seen = digits_seen + 1'b1;
   endtask

   task automatic push_char(input logic [7:0] c);
      step_results[step_count] = '0;
      step_results[step_count].out_char = c;
      step_count = step_count + 1;
      if (chars_emitted < CNT_MAX) chars_emitted = chars_emitted + 1'b1;
   endtask

   task automatic push_status(input logic stop, input logic [CNT_W-1:0] cons);
      step_results[step_count] = '0;
      step_results[step_count].kind        = 1'b1;
      step_results[step_count].stop_kind   = stop;
      step_results[step_count].consumed    = cons;
      step_results[step_count].out_length  = chars_emitted;
      step_results[step_count].digit_total = digits_seen;
      step_results[step_count].imaginary   = imag_seen;
      step_count = step_count + 1;
   endtask

   // Advances the scanner by one character and leaves its result items in step_results.
   task automatic scan_next_char(input logic [7:0] c, input logic eot);
      logic [7:0] dot_ch;
      logic [7:0] sep_ch;
      phase_type  ph;
      logic       stopped;
      dot_ch     = cfg.decimal_is_period ? CH_PERIOD : CH_COMMA;
      sep_ch     = cfg.decimal_is_period ? CH_COMMA : CH_PERIOD;
      ph         = scan_phase;
      stopped    = 1'b0;
      step_count = 0;
      if (scan_done) begin
         // Everything after the stop is ignored until the end of the text.
         if (eot) clear_scan();
      end else if (char_pos >= MAX_CHARS) begin
         // A character past the length limit is never examined; the text counts as spent.
         push_status(1'b1, 7'(MAX_CHARS));
         scan_done = 1'b1;
         if (eot) clear_scan();
      end else begin
         if (c == CH_PLUS || c == CH_MINUS) begin
            if (ph == PH_NONE || ph == PH_E) begin
               if (c == CH_MINUS) push_char(c);
               ph = (ph == PH_NONE) ? PH_SIGN : PH_EXP;
            end else if (ph == PH_INT || ph == PH_FRAC || ph == PH_EXP || ph == PH_POSTIM) begin
               ph = PH_NEXT;
            end else begin
               ph = PH_ILLEGAL;
            end
         end else if (c >= CH_ZERO && c <= CH_NINE) begin
            if (ph == PH_NONE || ph == PH_SIGN || ph == PH_INT || ph == PH_FRAC ||
                ph == PH_EXP || ph == PH_E) begin
               push_char(c);
               count_digit();
               if (ph == PH_NONE || ph == PH_SIGN) ph = PH_INT;
               else if (ph == PH_E) ph = PH_EXP;
            end else begin
               ph = PH_ILLEGAL;
            end
         end else if (cfg.separators_enabled && c == sep_ch) begin
            if (ph != PH_INT && ph != PH_FRAC) ph = PH_ILLEGAL;
         end else if (c == dot_ch) begin
            if (ph == PH_NONE || ph == PH_SIGN || ph == PH_INT) begin
               // A bare decimal point gets a leading zero.
               if (ph != PH_INT) push_char(CH_ZERO);
               push_char(dot_ch);
               ph = PH_FRAC;
            end else begin
               ph = PH_ILLEGAL;
            end
         end else if (c == CH_UPPER_E || c == CH_LOWER_E) begin
            if (ph == PH_SIGN || ph == PH_INT || ph == PH_FRAC) begin
               // A bare exponent letter gets a leading one.
               if (ph == PH_SIGN) begin
                  push_char(CH_ONE);
                  count_digit();
               end
               push_char(CH_LOWER_E);
               ph = PH_E;
            end else begin
               ph = PH_ILLEGAL;
            end
         end else if (c == CH_LOWER_I && !cfg.real_only) begin
            if (ph == PH_NONE || ph == PH_SIGN) begin
               imag_seen = 1'b1;
               ph = PH_INT;
            end else if (ph == PH_INT || ph == PH_FRAC || ph == PH_EXP) begin
               imag_seen = 1'b1;
               ph = PH_POSTIM;
            end else begin
               ph = PH_ILLEGAL;
            end
         end else if (c == CH_SPACE) begin
            if (ph == PH_INT || ph == PH_FRAC || ph == PH_EXP || ph == PH_POSTIM) ph = PH_NEXT;
            else if (ph != PH_NONE && ph != PH_SIGN) ph = PH_ILLEGAL;
         end else if (ph != PH_NONE) begin
            ph = PH_ILLEGAL;
         end

         if (ph == PH_ILLEGAL || ph == PH_NEXT) begin
            if (digits_seen == 0 && imag_seen) begin
               // A lone i stands for one times i.
               push_char(CH_ONE);
               count_digit();
               stopped = 1'b1;
            end else if (digits_seen == 0) begin
               // Nothing numeric yet: drop the header and keep looking.
               ph = PH_NONE;
            end else begin
               stopped = 1'b1;
            end
         end
         scan_phase = ph;

         if (stopped) begin
            push_status((ph == PH_NEXT) ? 1'b0 : 1'b1, char_pos);
            scan_done = 1'b1;
         end else begin
            char_pos = char_pos + 1'b1;
            if (eot) begin
               push_status(1'b1, char_pos);
               scan_done = 1'b1;
            end
         end
         if (eot) clear_scan();
      end
      if (step_count > 0) step_results[step_count - 1].last = 1'b1;
   endtask

   task automatic check_field(input string name, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
         fail_count = fail_count + 1;
      end
   endtask

   // Outputs are sampled at the rising edge. A result taken at this edge always belongs
   // to an item accepted at an earlier edge, so the check runs before the new prediction.
   always @(posedge clock) begin : result_monitor
      result_type got;
      result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_kind, rsp_out_char, rsp_stop_kind, rsp_consumed, rsp_out_length,
                   rsp_digit_total, rsp_imaginary, rsp_last};
            results_checked = results_checked + 1;
            if (got.kind) status_seen = status_seen + 1;
            if (token_results_due.size() == 0) begin
               $display("%0t: result item with nothing expected, actual %h", $time, got);
               fail_count = fail_count + 1;
            end else begin
               want = token_results_due.pop_front();
               check_field("kind", want.kind, got.kind);
               check_field("out_char", want.out_char, got.out_char);
               check_field("stop_kind", want.stop_kind, got.stop_kind);
               check_field("consumed", want.consumed, got.consumed);
               check_field("out_length", want.out_length, got.out_length);
               check_field("digit_total", want.digit_total, got.digit_total);
               check_field("imaginary", want.imaginary, got.imaginary);
               check_field("last", want.last, got.last);
            end
         end
         if (req_valid && req_ready) begin
            scan_next_char(req_ch, req_end_of_text);
            if (typed_active) begin
               token_results_due.push_back(typed_want);
            end else begin
               for (int k = 0; k < step_count; k++) token_results_due.push_back(step_results[k]);
            end
         end
      end
   end

   // Offers one item at a falling edge, after a random gap, and returns at the falling
   // edge that follows its acceptance. Valid stays high into the next call.
   task automatic send_item(input logic [7:0] c, input logic eot, input logic typed,
                            input result_type want);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_ch          <= c;
      req_end_of_text <= eot;
      typed_active    <= typed;
      typed_want      <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent = items_sent + 1;
      if (eot) texts_sent = texts_sent + 1;
   endtask

   // Holds the sender off until every owed result has come back, then waits out the
   // settling period so that nothing is left in flight.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (token_results_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_settings(input logic dec_period, input logic seps_on,
                                 input logic real_mode);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DECIMAL_IS_PERIOD;
      csr_wdata <= dec_period;
      @(negedge clock);
      csr_index <= CSR_SEPARATORS_ENABLED;
      csr_wdata <= seps_on;
      @(negedge clock);
      csr_index <= CSR_REAL_ONLY;
      csr_wdata <= real_mode;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cfg.decimal_is_period  = dec_period;
      cfg.separators_enabled = seps_on;
      cfg.real_only          = real_mode;
      settings_used = settings_used + 1;
   endtask

   function automatic logic [7:0] pick_digit();
      return CH_ZERO + 8'($urandom_range(9));
   endfunction

   // Any character class the scanner knows, or a raw byte.
   function automatic logic [7:0] pick_token();
      case ($urandom_range(9))
         0: return pick_digit();
         1: return CH_PLUS;
         2: return CH_MINUS;
         3: return CH_PERIOD;
         4: return CH_COMMA;
         5: return CH_UPPER_E;
         6: return CH_LOWER_E;
         7: return CH_LOWER_I;
         8: return CH_SPACE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic push_digit_run(input int n, input logic with_seps);
      logic [7:0] sep_ch;
      sep_ch = cfg.decimal_is_period ? CH_COMMA : CH_PERIOD;
      for (int k = 0; k < n; k++) begin
         if (with_seps && k > 0 && $urandom_range(99) < 15) text_buf.push_back(sep_ch);
         text_buf.push_back(pick_digit());
      end
   endtask

   // A number built from random, possibly empty parts, framed by junk and an optional random terminator.
   task automatic build_number_text();
      text_buf.delete();
      repeat ($urandom_range(2))
         text_buf.push_back($urandom_range(1) ? CH_SPACE : 8'($urandom_range(255)));
      case ($urandom_range(2))
         1: text_buf.push_back(CH_PLUS);
         2: text_buf.push_back(CH_MINUS);
         default: ;
      endcase
      push_digit_run($urandom_range(5), 1'b1);
      if ($urandom_range(1)) begin
         text_buf.push_back(cfg.decimal_is_period ? CH_PERIOD : CH_COMMA);
         push_digit_run($urandom_range(4), 1'b1);
      end
      if ($urandom_range(99) < 35) begin
         text_buf.push_back($urandom_range(1) ? CH_UPPER_E : CH_LOWER_E);
         case ($urandom_range(2))
            1: text_buf.push_back(CH_PLUS);
            2: text_buf.push_back(CH_MINUS);
            default: ;
         endcase
         push_digit_run($urandom_range(3), 1'b0);
      end
      if ($urandom_range(99) < 25) text_buf.push_back(CH_LOWER_I);
      case ($urandom_range(4))
         1: text_buf.push_back(CH_SPACE);
         2: text_buf.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
         3: text_buf.push_back(8'($urandom_range(255)));
         4: text_buf.push_back(CH_LOWER_I);
         default: ;
      endcase
      repeat ($urandom_range(3)) text_buf.push_back(pick_token());
      if (text_buf.size() == 0) text_buf.push_back(pick_digit());
   endtask

   task automatic build_token_text();
      text_buf.delete();
      repeat (1 + $urandom_range(9)) text_buf.push_back(pick_token());
   endtask

   task automatic build_noise_text();
      text_buf.delete();
      repeat (1 + $urandom_range(7)) text_buf.push_back(8'($urandom_range(255)));
   endtask

   // Enough digits to run past the length limit.
   task automatic build_long_text();
      text_buf.delete();
      push_digit_run(MAX_CHARS + 1 + $urandom_range(5), 1'b0);
   endtask

   task automatic send_text();
      for (int k = 0; k < text_buf.size(); k++)
         send_item(text_buf[k], k == text_buf.size() - 1, 1'b0, '0);
   endtask

   initial begin : stimulus
      stim_row_type row;
      int           first_item;
      int           texts_in_phase;
      int           choice;
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_ch          = '0;
      req_end_of_text = 1'b0;
      rsp_ready       = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_DECIMAL_IS_PERIOD;
      csr_wdata       = 1'b0;
      typed_active    = 1'b0;
      typed_want      = '0;
      send_idle_pct   = 13;
      recv_idle_pct   = 55;
      fail_count      = 0;
      items_sent      = 0;
      texts_sent      = 0;
      results_checked = 0;
      status_seen     = 0;
      settings_used   = 1;
      cycle_count     = 0;
      cfg.decimal_is_period  = 1'b1;
      cfg.separators_enabled = 1'b0;
      cfg.real_only          = 1'b0;
      clear_scan();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed texts run under the reset settings.
      for (int k = 0; k < DIRECTED_LEN; k++) begin
         row = DIRECTED[k];
         send_item(row.ch, row.eot, row.typed, row.want);
      end

      // Three random phases: sender idles lightly with a slow receiver, then the reverse,
      // then both run flat out. Each phase opens with fixed settings that include the
      // all-clear and all-set extremes, and the settings are reshuffled every few texts.
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 13 : (p == 1) ? 55 : 0;
         recv_idle_pct = (p == 0) ? 55 : (p == 1) ? 13 : 0;
         write_settings(p == 1, p != 2, p != 2);
         first_item     = items_sent;
         texts_in_phase = 0;
         if (p > 0) begin
            build_long_text();
            send_text();
         end
         while (items_sent - first_item < PHASE_ITEMS) begin
            if (texts_in_phase % 6 == 5)
               write_settings($urandom_range(1), $urandom_range(1), $urandom_range(1));
            choice = $urandom_range(99);
            if (choice < 70) build_number_text();
            else if (choice < 87) build_token_text();
            else build_noise_text();
            send_text();
            texts_in_phase = texts_in_phase + 1;
         end
      end

      wait_drained();
      $display("Scanned %0d characters in %0d texts under %0d register settings.",
               items_sent, texts_sent, settings_used);
      $display("Compared %0d result items, %0d of them status items; %0d field errors.",
               results_checked, status_seen, fail_count);
      if (fail_count == 0) begin
         $display("PASS numeric_token_extractor_core");
      end else begin
         $display("FAIL numeric_token_extractor_core");
      end
      $finish;
   end

endmodule
